>>> hw/rtl/pipw_pkg.sv
// ----------------------------------------------------------------------------
// pipw_pkg
// Types, constants and helper functions shared by the point-in-polygon
// winding block and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package pipw_pkg;

  // Field and datapath widths
  localparam int COORD_W = 32;            // vertex and point coordinates
  localparam int DIFF_W  = COORD_W + 1;   // coordinate minus point, exact
  localparam int PROD_W  = 2 * DIFF_W;    // exact cross product term
  localparam int SUM_W   = 16;            // running turn sum, wraps
  localparam int TURN_W  = 3;             // one edge turn, -2 .. +2
  localparam int CFG_IDX_W = 1;           // configuration register index

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y = 1'd1;

  typedef logic [1:0] quad_t;
  typedef logic [1:0] seen_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [TURN_W-1:0]  turn_t;

  // Quadrants around the query point
  localparam quad_t Q_UPPER_RIGHT = 2'd0;  // x >  px, y >  py
  localparam quad_t Q_LOWER_RIGHT = 2'd1;  // x >  px, y <= py
  localparam quad_t Q_LOWER_LEFT  = 2'd2;  // x <= px, y <  py
  localparam quad_t Q_UPPER_LEFT  = 2'd3;  // x <= px, y >= py

  // Quadrant step, new minus old, modulo four
  localparam quad_t QD_SAME = 2'd0;
  localparam quad_t QD_FWD  = 2'd1;
  localparam quad_t QD_DIAG = 2'd2;
  localparam quad_t QD_BACK = 2'd3;

  // Saturation value of the vertex count
  localparam seen_t SEEN_MAX = 2'd3;

  // Class a vertex into its quadrant around the point
  function automatic quad_t classify(coord_t x, coord_t y, coord_t px, coord_t py);
    quad_t q;
    if (x > px) begin
      q = (y > py) ? Q_UPPER_RIGHT : Q_LOWER_RIGHT;
    end else begin
      q = (y < py) ? Q_LOWER_LEFT : Q_UPPER_LEFT;
    end
    return q;
  endfunction

  // Turn contributed by one edge; cw is set when the cross product is negative
  function automatic turn_t edge_turn(quad_t q, quad_t nq, logic cw);
    turn_t t;
    quad_t d;
    d = nq - q;
    case (d)
      QD_FWD:  t = 3'sd1;
      QD_BACK: t = -3'sd1;
      QD_DIAG: t = cw ? 3'sd2 : -3'sd2;
      default: t = 3'sd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pipw_vertex_if.sv
// ----------------------------------------------------------------------------
// pipw_vertex_if
// Vertex stream channel: one polygon vertex per word, final vertex flagged.
// ----------------------------------------------------------------------------
`default_nettype none

interface pipw_vertex_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       vertex_x;
  logic signed [31:0]       vertex_y;
  logic                     last_vertex;

  modport source (output valid, output vertex_x, output vertex_y,
                  output last_vertex, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y,
                  input last_vertex, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pipw_result_if.sv
// ----------------------------------------------------------------------------
// pipw_result_if
// Result channel: one word per polygon with the containment verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface pipw_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few_vertices;

  modport source (output valid, output inside_res, output too_few_vertices,
                  input ready);
  modport sink   (input valid, input inside_res, input too_few_vertices,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/point_in_polygon_winding.sv
// ----------------------------------------------------------------------------
// point_in_polygon_winding
// Quadrant winding-number test of a configured point against a streamed
// polygon, one vertex per cycle unless result backpressure stalls the input.
// ----------------------------------------------------------------------------
// The block takes one vertex per clock and returns one word per polygon. A
// last vertex is taken into the input register at the accepting edge, then
// into the register behind the four exact 33x33-bit cross product
// multipliers, and then into the result register. Sustained rate is one
// vertex per cycle; backpressure on the result channel stalls only once a
// finished result is waiting and another last vertex reaches the product
// stage. The query point is written through the configuration port while no
// vertex is in flight; a polygon with fewer than three vertices reports
// too_few_vertices and not inside.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_winding
  import pipw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_W-1:0]    cfg_data,
  pipw_vertex_if.sink                vertex,
  pipw_result_if.source              result
);

  // Query point
  coord_t point_x;
  coord_t point_y;

  // Input stage
  logic   s1_valid;
  coord_t s1_x;
  coord_t s1_y;
  logic   s1_last;

  // Polygon state
  coord_t prev_vx;
  coord_t prev_vy;
  coord_t first_vx;
  coord_t first_vy;
  quad_t  prev_quad;
  quad_t  first_quad;
  seen_t  seen_count;

  // Product stage
  logic   s2_valid;
  logic   s2_last;
  logic   s2_step_en;
  logic   s2_close_en;
  logic   s2_too_few;
  quad_t  s2_q_prev;
  quad_t  s2_q_cur;
  quad_t  s2_q_first;
  prod_t  s2_p_step_a;
  prod_t  s2_p_step_b;
  prod_t  s2_p_close_a;
  prod_t  s2_p_close_b;

  // Accumulator and result register
  sum_t   turn_sum;
  logic   o_valid;
  logic   o_inside;
  logic   o_too_few;

  // Handshake chain
  logic   out_free;
  logic   s2_adv;
  logic   s2_free;
  logic   s1_adv;
  logic   s1_free;

  // Stage 1 datapath
  diff_t  dx;
  diff_t  dy;
  diff_t  prev_dx;
  diff_t  prev_dy;
  diff_t  first_dx;
  diff_t  first_dy;
  quad_t  q_cur;
  seen_t  count_next;

  // Stage 2 datapath
  turn_t  t_step;
  turn_t  t_close;
  sum_t   sum_step;
  sum_t   sum_close;

  // Advance each stage when the one behind it has room
  assign out_free = !o_valid || result.ready;
  assign s2_adv   = s2_valid && (!s2_last || out_free);
  assign s2_free  = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_adv;

  assign vertex.ready            = s1_free;
  assign result.valid            = o_valid;
  assign result.inside_res       = o_inside;
  assign result.too_few_vertices = o_too_few;

  // Write the query point
  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0;
      point_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_X: point_x <= coord_t'(cfg_data);
        CFG_POINT_Y: point_y <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Capture an incoming vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= vertex.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && vertex.valid) begin
      s1_x    <= vertex.vertex_x;
      s1_y    <= vertex.vertex_y;
      s1_last <= vertex.last_vertex;
    end
  end

  // Offsets from the point and cross product terms
  assign dx       = DIFF_W'(s1_x) - DIFF_W'(point_x);
  assign dy       = DIFF_W'(s1_y) - DIFF_W'(point_y);
  assign prev_dx  = DIFF_W'(prev_vx) - DIFF_W'(point_x);
  assign prev_dy  = DIFF_W'(prev_vy) - DIFF_W'(point_y);
  assign first_dx = DIFF_W'(first_vx) - DIFF_W'(point_x);
  assign first_dy = DIFF_W'(first_vy) - DIFF_W'(point_y);

  assign q_cur      = classify(s1_x, s1_y, point_x, point_y);
  assign count_next = (seen_count == SEEN_MAX) ? SEEN_MAX : seen_count + 2'd1;

  // Update the polygon state as a vertex leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vx    <= '0;
      prev_vy    <= '0;
      first_vx   <= '0;
      first_vy   <= '0;
      prev_quad  <= Q_UPPER_RIGHT;
      first_quad <= Q_UPPER_RIGHT;
      seen_count <= '0;
    end else if (s1_adv) begin
      prev_vx   <= s1_x;
      prev_vy   <= s1_y;
      prev_quad <= q_cur;
      if (seen_count == '0) begin
        first_vx   <= s1_x;
        first_vy   <= s1_y;
        first_quad <= q_cur;
      end
      seen_count <= s1_last ? '0 : count_next;
    end
  end

  // Product stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  // Register the products and edge controls
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last      <= s1_last;
      s2_step_en   <= (seen_count != '0);
      s2_close_en  <= s1_last && (count_next == SEEN_MAX);
      s2_too_few   <= s1_last && (count_next != SEEN_MAX);
      s2_q_prev    <= prev_quad;
      s2_q_cur     <= q_cur;
      s2_q_first   <= first_quad;
      s2_p_step_a  <= PROD_W'(prev_dx) * PROD_W'(dy);
      s2_p_step_b  <= PROD_W'(prev_dy) * PROD_W'(dx);
      s2_p_close_a <= PROD_W'(dx) * PROD_W'(first_dy);
      s2_p_close_b <= PROD_W'(dy) * PROD_W'(first_dx);
    end
  end

  // Score the incoming edge and, on the last vertex, the closing edge
  assign t_step    = edge_turn(s2_q_prev, s2_q_cur, s2_p_step_a < s2_p_step_b);
  assign t_close   = edge_turn(s2_q_cur, s2_q_first, s2_p_close_a < s2_p_close_b);
  assign sum_step  = s2_step_en ? turn_sum + SUM_W'(t_step) : '0;
  assign sum_close = sum_step + (s2_close_en ? SUM_W'(t_close) : '0);

  // Accumulate the turn sum; drop it at the end of a polygon
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_sum <= '0;
    end else if (s2_adv) begin
      turn_sum <= s2_last ? '0 : sum_step;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s2_adv && s2_last) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_last) begin
      o_inside  <= s2_close_en && (sum_close != '0);
      o_too_few <= s2_too_few;
    end
  end

`ifndef SYNTHESIS
  // A polygon is never both too small and enclosing the point
  a_verdict_exclusive: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(o_inside && o_too_few))
    else $error("result flags inside and too few vertices together");

  // Input stalls only behind a last vertex held in the product stage while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !vertex.ready |-> s1_valid && s2_valid && s2_last && o_valid && !result.ready)
    else $error("input stalled without a blocked last vertex ahead");

  // The last vertex of a polygon restarts the vertex count
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> seen_count == '0)
    else $error("vertex count not cleared after last vertex");

  // The turn sum is clear whenever a polygon begins
  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    s2_adv && s2_last |=> turn_sum == '0)
    else $error("turn sum not cleared after a polygon");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !s1_valid && !s2_valid && !o_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

>>> bench/pipw_verdict_checker.sv
// ----------------------------------------------------------------------------
// pipw_verdict_checker
// Watches the configuration port and both channels of the point-in-polygon
// block. It keeps its own quadrant winding state, predicts the verdict for
// every closed polygon and compares each result word field by field.
// ----------------------------------------------------------------------------

module pipw_verdict_checker
  import pipw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  pipw_vertex_if                vertex,
  pipw_result_if                result,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic enclosed;
    logic too_few;
  } verdict_t;

  verdict_t verdicts_due[$];

  // Predictor state
  coord_t pt_x, pt_y;
  coord_t prev_x, prev_y, first_x, first_y;
  quad_t  prev_q, first_q;
  sum_t   winding;
  seen_t  seen;
  int     errors = 0;

  // Quadrant of a vertex around the query point
  function automatic quad_t quadrant_of(coord_t x, coord_t y, coord_t px, coord_t py);
    if (x > px) begin
      return (y > py) ? Q_UPPER_RIGHT : Q_LOWER_RIGHT;
    end
    return (y < py) ? Q_LOWER_LEFT : Q_UPPER_LEFT;
  endfunction

  // Winding contribution of the edge a -> b; diagonal sign from the exact cross product
  function automatic int edge_winding(quad_t from_q, quad_t to_q, coord_t ax, coord_t ay,
                                      coord_t bx, coord_t by, coord_t px, coord_t py);
    logic signed [67:0] dax, day, dbx, dby;
    logic signed [67:0] lhs, rhs;
    quad_t step;
    dax = ax;
    day = ay;
    dbx = bx;
    dby = by;
    dax = dax - px;
    day = day - py;
    dbx = dbx - px;
    dby = dby - py;
    step = to_q - from_q;
    case (step)
      QD_FWD:  return 1;
      QD_BACK: return -1;
      QD_DIAG: begin
        lhs = dax * dby;
        rhs = day * dbx;
        return (lhs < rhs) ? 2 : -2;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : track
    verdict_t got;
    verdict_t want;
    coord_t   vx, vy;
    quad_t    q;
    if (rst) begin
      verdicts_due.delete();
      pt_x    = '0;
      pt_y    = '0;
      prev_x  = '0;
      prev_y  = '0;
      first_x = '0;
      first_y = '0;
      prev_q  = Q_UPPER_RIGHT;
      first_q = Q_UPPER_RIGHT;
      winding = '0;
      seen    = '0;
    end else begin
      // Apply register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_POINT_X: pt_x = cfg_data;
          CFG_POINT_Y: pt_y = cfg_data;
          default: ;
        endcase
      end

      // Compare a result word against the oldest verdict
      if (result.valid && result.ready) begin
        got.enclosed = result.inside_res;
        got.too_few  = result.too_few_vertices;
        if (verdicts_due.size() == 0) begin
          report($sformatf("result word with nothing due: inside_res=%0b too_few_vertices=%0b",
                           got.enclosed, got.too_few));
        end else begin
          want = verdicts_due.pop_front();
          if (got.enclosed !== want.enclosed) begin
            report($sformatf("inside_res got %0b want %0b", got.enclosed, want.enclosed));
          end
          if (got.too_few !== want.too_few) begin
            report($sformatf("too_few_vertices got %0b want %0b", got.too_few, want.too_few));
          end
        end
      end

      // Advance the winding state on an accepted vertex word
      if (vertex.valid && vertex.ready) begin
        vx = vertex.vertex_x;
        vy = vertex.vertex_y;
        q  = quadrant_of(vx, vy, pt_x, pt_y);
        if (seen == 0) begin
          first_q = q;
          first_x = vx;
          first_y = vy;
          winding = '0;
        end else begin
          winding = winding + sum_t'(edge_winding(prev_q, q, prev_x, prev_y, vx, vy,
                                                  pt_x, pt_y));
        end
        prev_q = q;
        prev_x = vx;
        prev_y = vy;
        if (seen != SEEN_MAX) begin
          seen = seen + 1'b1;
        end
        if (vertex.last_vertex) begin
          if (seen != SEEN_MAX) begin
            want.enclosed = 1'b0;
            want.too_few  = 1'b1;
          end else begin
            // Close the polygon back to its first vertex
            winding = winding + sum_t'(edge_winding(q, first_q, vx, vy, first_x, first_y,
                                                    pt_x, pt_y));
            want.enclosed = (winding != 0);
            want.too_few  = 1'b0;
          end
          verdicts_due = {verdicts_due, want};
          seen    = '0;
          winding = '0;
        end
      end
    end
    pending    <= verdicts_due.size();
    fail_count <= errors;
  end

endmodule

>>> bench/tb_point_in_polygon_winding.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_winding
// Drives polygons vertex by vertex into the winding-number block under
// several query points, with bursty input and a stalling result side. A
// checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------

module tb_point_in_polygon_winding
  import pipw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HALF_PERIOD     = 10;
  localparam int     DRAIN_CYCLES    = 8;
  localparam int     HOLD_CYCLES     = 250;
  localparam int     QUIET_LIMIT     = 4000;
  localparam int     PHASES          = 6;
  localparam int     ITEMS_PER_PHASE = 250;
  localparam int     WRAP_LAPS       = 32;
  localparam coord_t C_MIN           = 32'sh8000_0000;
  localparam coord_t C_MAX           = 32'sh7fff_ffff;

  typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE, RX_PULSE} rx_mode_t;
  typedef enum logic [1:0] {SHAPE_SCATTER, SHAPE_RING, SHAPE_NEAR} shape_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;
  int                   fail_count;
  int                   pending;
  int                   hold_reqs = 0;
  int                   burst_left = 0;
  coord_t               px_cur = '0;
  coord_t               py_cur = '0;

  pipw_vertex_if vertex();
  pipw_result_if result();

  point_in_polygon_winding i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vertex    (vertex),
    .result    (result)
  );

  pipw_verdict_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vertex     (vertex),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Offer one vertex word, in bursts with random gaps between them
  task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
    if (burst_left == 0) begin
      vertex.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 12);
    end
    vertex.valid       <= 1'b1;
    vertex.vertex_x    <= x;
    vertex.vertex_y    <= y;
    vertex.last_vertex <= last;
    @(posedge clk);
    while (!vertex.ready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid, wait for every verdict, then let the pipeline drain
  task automatic settle();
    vertex.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both point registers back to back
  task automatic set_point(input coord_t x, input coord_t y);
    px_cur = x;
    py_cur = y;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POINT_X;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= CFG_POINT_Y;
    cfg_data  <= y;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t offset_coord(coord_t base, longint delta);
    longint v;
    v = longint'(base) + delta;
    if (v > longint'(C_MAX)) v = longint'(C_MAX);
    if (v < longint'(C_MIN)) v = longint'(C_MIN);
    return v[31:0];
  endfunction

  // Place a vertex in the given quadrant around the current point
  task automatic pick_in_quadrant(input quad_t q, input int unsigned span,
                                  output coord_t x, output coord_t y);
    longint ax, ay;
    ax = longint'($urandom_range(1, span));
    ay = longint'($urandom_range(1, span));
    case (q)
      Q_UPPER_RIGHT: begin
        x = offset_coord(px_cur, ax);
        y = offset_coord(py_cur, ay);
      end
      Q_LOWER_RIGHT: begin
        x = offset_coord(px_cur, ax);
        y = offset_coord(py_cur, -(ay - 1));
      end
      Q_LOWER_LEFT: begin
        x = offset_coord(px_cur, -(ax - 1));
        y = offset_coord(py_cur, -ay);
      end
      default: begin
        x = offset_coord(px_cur, -(ax - 1));
        y = offset_coord(py_cur, ay - 1);
      end
    endcase
  endtask

  task automatic send_polygon(input int count, input shape_t shape, input int unsigned span);
    quad_t  q;
    quad_t  dir;
    coord_t x, y;
    q   = quad_t'($urandom_range(0, 3));
    dir = $urandom_range(0, 1) ? QD_FWD : QD_BACK;
    for (int i = 0; i < count; i++) begin
      case (shape)
        SHAPE_RING: begin
          pick_in_quadrant(q, span, x, y);
          // mostly walk around the point, now and then jump across or stay
          case ($urandom_range(0, 7))
            0:       q = q + QD_DIAG;
            1:       q = q + QD_SAME;
            default: q = q + dir;
          endcase
        end
        SHAPE_NEAR: begin
          x = offset_coord(px_cur, longint'($urandom_range(0, 8)) - 4);
          y = offset_coord(py_cur, longint'($urandom_range(0, 8)) - 4);
        end
        default: begin
          x = $urandom;
          y = $urandom;
        end
      endcase
      send_vertex(x, y, i == count - 1);
    end
  endtask

  // Result side: changing stall pattern plus an on-request long hold-off
  initial begin : receiver
    rx_mode_t mode;
    int       left;
    int       hold;
    int       hold_done;
    result.ready <= 1'b0;
    mode      = RX_FREE;
    left      = 0;
    hold      = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold      = HOLD_CYCLES;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 128);
      end
      left--;
      if (hold > 0) begin
        hold--;
        result.ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:   result.ready <= 1'b1;
          RX_HALF:   result.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: result.ready <= ($urandom_range(0, 3) == 0);
          default:   result.ready <= ((left % 8) < 5);
        endcase
      end
    end
  end

  // End the run when no word moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((vertex.valid && vertex.ready) || (result.valid && result.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("point_in_polygon_winding verification failed");
    $finish;
  end

  initial begin : stimulus
    quad_t       lap_order [4];
    coord_t      x, y, nx, ny;
    int          sent, count, sel;
    shape_t      shape;
    int unsigned span;
    lap_order = '{Q_UPPER_RIGHT, Q_LOWER_RIGHT, Q_LOWER_LEFT, Q_UPPER_LEFT};

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_POINT_X;
    cfg_data           <= '0;
    vertex.valid       <= 1'b0;
    vertex.vertex_x    <= '0;
    vertex.vertex_y    <= '0;
    vertex.last_vertex <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed polygons around the origin
    set_point(0, 0);
    // clockwise square
    send_vertex(10, 10, 1'b0);
    send_vertex(10, -10, 1'b0);
    send_vertex(-10, -10, 1'b0);
    send_vertex(-10, 10, 1'b1);
    // diagonal jump with a zero cross product
    send_vertex(5, 5, 1'b0);
    send_vertex(-5, -5, 1'b0);
    send_vertex(5, -5, 1'b1);
    // one and two vertices
    send_vertex(C_MAX, C_MIN, 1'b1);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    // extreme corners, exact cross products
    send_vertex(C_MAX, C_MAX, 1'b0);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b1);
    // vertex on the point and on the axes
    send_vertex(0, 0, 1'b0);
    send_vertex(1, 0, 1'b0);
    send_vertex(0, -1, 1'b1);
    // triangle off to one side
    send_vertex(5, 5, 1'b0);
    send_vertex(6, 5, 1'b0);
    send_vertex(5, 6, 1'b1);
    settle();
    set_point(C_MIN, C_MAX);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    // move the point in the middle of a polygon
    settle();
    set_point(0, 0);
    send_vertex(10, 10, 1'b0);
    send_vertex(10, -10, 1'b0);
    settle();
    set_point(20, 0);
    send_vertex(-10, -10, 1'b0);
    send_vertex(-10, 10, 1'b1);

    // Long clockwise loop of many laps around the point
    settle();
    set_point(int'($urandom_range(0, 64)) - 32, int'($urandom_range(0, 64)) - 32);
    for (int lap = 0; lap < WRAP_LAPS; lap++) begin
      for (int k = 0; k < 4; k++) begin
        pick_in_quadrant(lap_order[k], 32'd1 << 20, x, y);
        send_vertex(x, y, (lap == WRAP_LAPS - 1) && (k == 3));
      end
    end

    // Random polygons under several query points
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin nx = $urandom; ny = $urandom; end
        1: begin nx = C_MIN; ny = C_MIN; end
        2: begin nx = C_MAX; ny = C_MAX; end
        3: begin nx = C_MIN; ny = C_MAX; end
        4: begin nx = C_MAX; ny = C_MIN; end
        default: begin
          nx = int'($urandom_range(0, 32)) - 16;
          ny = int'($urandom_range(0, 32)) - 16;
        end
      endcase
      settle();
      set_point(nx, ny);
      if (p == 0) begin
        // hold the result side while triangles keep coming
        hold_reqs++;
        repeat (30) send_polygon(3, SHAPE_RING, 1000);
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          count = $urandom_range(1, 2);
        end else if (sel == 1) begin
          count = $urandom_range(13, 40);
        end else begin
          count = $urandom_range(3, 8);
        end
        shape = shape_t'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0:       span = 16;
          1:       span = 65536;
          default: span = 32'h8000_0000;
        endcase
        send_polygon(count, shape, span);
        sent += count;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("point_in_polygon_winding verification clean");
    end else begin
      $display("point_in_polygon_winding verification failed");
    end
    $finish;
  end

endmodule
